// ----- sv/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared widths, constants, types and the digit-to-ASCII function of the
// radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_VALUE_W  = 32;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(65 - 10);
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic read;
        logic show;
        logic err_show;
    } itrd_cmd_t;

    typedef struct packed {
        logic step_last;
        logic quo_zero;
        logic radix_bad;
        logic out_fire;
        logic out_last;
    } itrd_status_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] base;
        base = (d > DIGIT_NINE) ? CHAR_LETTER : CHAR_ZERO;
        return base + CHAR_W'(d);
    endfunction

endpackage

// ----- sv/itrd_in_if.sv -----
// ----------------------------------------------------------------------------
// itrd_in_if
// Request channel: one beat carries a value and the radix to convert it to.
// ----------------------------------------------------------------------------
interface itrd_in_if;

    logic                                  valid;
    logic                                  ready;
    logic [itrd_pkg::IN_VALUE_W-1:0]       value;
    logic [itrd_pkg::RADIX_W-1:0]          radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);

endinterface

// ----- sv/itrd_out_if.sv -----
// ----------------------------------------------------------------------------
// itrd_out_if
// Digit channel: one beat carries one ASCII digit and its flags.
// ----------------------------------------------------------------------------
interface itrd_out_if;

    logic                           valid;
    logic                           ready;
    logic [itrd_pkg::CHAR_W-1:0]    digit_char;
    logic                           last;
    logic                           bad_radix;

    modport source (output valid, output digit_char, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input digit_char, input last, input bad_radix,
                    output ready);

endinterface

// ----- sv/itrd_datapath.sv -----
// ----------------------------------------------------------------------------
// itrd_datapath
// Bit-serial restoring divider, remainder store and the output register.
// ----------------------------------------------------------------------------
module itrd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  itrd_pkg::itrd_cmd_t               cmd,
    output itrd_pkg::itrd_status_t            status,
    input  logic [itrd_pkg::IN_VALUE_W-1:0]   value,
    input  logic [itrd_pkg::RADIX_W-1:0]      radix,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [itrd_pkg::CHAR_W-1:0]       digit_char,
    output logic                              last,
    output logic                              bad_radix
);

    logic [itrd_pkg::VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [itrd_pkg::DIGIT_W-1:0]     rem_reg, rem_next;
    logic [itrd_pkg::RADIX_W-1:0]     radix_reg;
    logic [itrd_pkg::STEP_W-1:0]      step_reg;
    logic [itrd_pkg::CNT_W-1:0]       cnt_reg;
    logic [itrd_pkg::CNT_W-1:0]       cnt_m1;
    logic                             out_valid_reg;
    logic [itrd_pkg::CHAR_W-1:0]      digit_char_reg;
    logic                             last_reg;
    logic                             bad_radix_reg;
    logic [itrd_pkg::DIGIT_W-1:0]     rd_data_reg;
    logic [itrd_pkg::DIGIT_W:0]       shifted;
    logic [itrd_pkg::DIGIT_W:0]       diff;
    logic                             fits;

    logic [itrd_pkg::DIGIT_W-1:0]     digit_mem [itrd_pkg::VALUE_WIDTH];

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[itrd_pkg::VALUE_WIDTH-1]};
        diff     = shifted - {1'b0, radix_reg};
        fits     = shifted >= {1'b0, radix_reg};
        rem_next = fits ? diff[itrd_pkg::DIGIT_W-1:0] : shifted[itrd_pkg::DIGIT_W-1:0];
        quo_next = {quo_reg[itrd_pkg::VALUE_WIDTH-2:0], fits};
    end

    assign cnt_m1 = cnt_reg - itrd_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg   <= '0;
            rem_reg   <= '0;
            radix_reg <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                quo_reg   <= itrd_pkg::VALUE_WIDTH'(value);
                radix_reg <= radix;
                rem_reg   <= '0;
                step_reg  <= '0;
                cnt_reg   <= '0;
            end
            else if (cmd.div_step)
            begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + itrd_pkg::STEP_W'(1);
            end
            else if (cmd.store)
            begin
                // The quotient stays in place as the next dividend.
                rem_reg  <= '0;
                step_reg <= '0;
                cnt_reg  <= cnt_reg + itrd_pkg::CNT_W'(1);
            end
            else if (cmd.read)
            begin
                cnt_reg <= cnt_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            digit_mem[cnt_reg[itrd_pkg::IDX_W-1:0]] <= rem_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= digit_mem[cnt_m1[itrd_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.show || cmd.err_show)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err_show)
        begin
            digit_char_reg <= '0;
            last_reg       <= 1'b1;
            bad_radix_reg  <= 1'b1;
        end
        else if (cmd.show)
        begin
            digit_char_reg <= itrd_pkg::digit_ascii(rd_data_reg);
            last_reg       <= (cnt_reg == '0);
            bad_radix_reg  <= 1'b0;
        end
    end

    always_comb
    begin
        status.step_last = (step_reg == itrd_pkg::STEP_W'(itrd_pkg::VALUE_WIDTH - 1));
        status.quo_zero  = (quo_reg == '0);
        status.radix_bad = !(radix inside {[itrd_pkg::RADIX_MIN:itrd_pkg::RADIX_MAX]});
        status.out_fire  = out_valid_reg && out_ready;
        status.out_last  = last_reg;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last       = last_reg;
    assign bad_radix  = bad_radix_reg;

endmodule

// ----- sv/itrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: runs one division per digit, then reads the stored digits back
// most significant first and hands them to the output register.
// ----------------------------------------------------------------------------
module itrd_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  itrd_pkg::itrd_status_t   status,
    output itrd_pkg::itrd_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_READ,
        S_SHOW,
        S_WAIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.radix_bad)
                    begin
                        cmd.err_show = 1'b1;
                        state_next   = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = status.quo_zero ? S_READ : S_DIV;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                cmd.show   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.out_fire)
                begin
                    state_next = status.out_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/integer_to_radix_digits_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts an unsigned integer to ASCII digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// Each request beat carries a value and a radix; the unit answers with one
// digit beat per digit, most significant first, with last set on the final
// one. A zero value gives the single digit '0'. A radix outside 2..36 gives a
// single beat with bad_radix and last set and digit_char zero. Digits come
// from a bit-serial restoring divider that produces one quotient bit per
// cycle; each digit takes a pass over every dividend bit and a store, and
// once all digits are stored each is read back, shown and held until the
// digit channel takes it. One request is handled at a time and the next is
// taken once the last digit beat of the current one has gone out.
module integer_to_radix_digits_unit (
    input  logic       clk,
    input  logic       rst_n,
    itrd_in_if.sink    request,
    itrd_out_if.source digits
);

    itrd_pkg::itrd_cmd_t    cmd;
    itrd_pkg::itrd_status_t status;

    itrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .status   (status),
        .cmd      (cmd)
    );

    itrd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .value      (request.value),
        .radix      (request.radix),
        .out_ready  (digits.ready),
        .out_valid  (digits.valid),
        .digit_char (digits.digit_char),
        .last       (digits.last),
        .bad_radix  (digits.bad_radix)
    );

    // No digit beat may be pending while a new request can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        request.ready |-> !digits.valid)
        else $error("digit beat pending while request channel is ready");

    // An error beat is always a lone, empty, final beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (digits.valid && digits.bad_radix) |-> (digits.last && digits.digit_char == '0))
        else $error("bad radix beat is not a single empty final beat");

    // A request with an unusable radix is answered by an error beat at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready &&
         (request.radix < itrd_pkg::RADIX_MIN || request.radix > itrd_pkg::RADIX_MAX))
        |=> (digits.valid && digits.bad_radix))
        else $error("bad radix request not answered by an error beat");

endmodule
